>>> design/ssc_pkg.sv
// shared types and constants for the sparse set component store
// no dependencies; imported by the front, back, top level and checker files
package ssc_pkg;

	localparam int ID_W   = 10;
	localparam int POS_W  = 10;
	localparam int WD_W   = 32;
	localparam int RD_W   = 32;
	localparam int STAT_W = 2;
	localparam int TOT_W  = 11;

	typedef enum logic [1:0] {
		REQ_LOOKUP  = 2'd0,
		REQ_SET     = 2'd1,
		REQ_REMOVE  = 2'd2,
		REQ_READ_AT = 2'd3
	} req_kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_RANGE  = 2'd2
	} status_t;

	typedef struct packed {
		req_kind_t        kind;
		logic [ID_W-1:0]  key_id;
		logic             in_range;
		logic [POS_W-1:0] dense_index;
		logic             pos_ok;
		logic [WD_W-1:0]  write_data;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		logic             found;
		logic [ID_W-1:0]  owner_id;
		logic [RD_W-1:0]  read_data;
		logic [POS_W-1:0] slot;
		logic [TOT_W-1:0] entry_total;
	} res_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} f2b_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} b2f_t;

endpackage

>>> design/ssc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ssc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/ssc_fifo.sv
// short flop based queue used between front and back and on the results
// no dependencies
module ssc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

>>> design/ssc_front.sv
// front end: accepts requests, classifies them and queues them for the back end
// depends on ssc_pkg and ssc_fifo
module ssc_front import ssc_pkg::*; #(
	parameter int MAX_ENTITIES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       req_type,
	input  logic [ID_W-1:0]  key_id,
	input  logic [POS_W-1:0] dense_index,
	input  logic [WD_W-1:0]  write_data,
	output f2b_t             f2b,
	input  b2f_t             b2f
);

	cmd_t cmd_in;
	logic q_full;
	logic q_empty;
	logic [$bits(cmd_t)-1:0] q_dout;

	always_comb begin
		cmd_in.kind        = req_kind_t'(req_type);
		cmd_in.key_id      = key_id;
		cmd_in.in_range    = (32'(key_id) < MAX_ENTITIES);
		cmd_in.dense_index = dense_index;
		cmd_in.pos_ok      = (32'(dense_index) < MAX_ENTITIES);
		cmd_in.write_data  = write_data;
	end

	// no request taken while the sparse table is being cleared
	assign full = q_full || b2f.clearing;

	ssc_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full),
		.din   (cmd_in),
		.full  (q_full),
		.pop   (b2f.take),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign f2b.valid = !q_empty;
	assign f2b.cmd   = cmd_t'(q_dout);

endmodule

>>> design/ssc_back.sv
// back end: sequencer over the sparse, owner and data memories, live count
// and result queue; depends on ssc_pkg, ssc_ram and ssc_fifo
module ssc_back import ssc_pkg::*; #(
	parameter int MAX_ENTITIES = 1024,
	parameter int DATA_WIDTH   = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  f2b_t f2b,
	output b2f_t b2f,
	input  logic pop,
	output logic empty,
	output res_t res
);

	localparam int IW  = $clog2(MAX_ENTITIES);
	localparam int CW  = $clog2(MAX_ENTITIES + 1);
	localparam int SPW = IW + 1;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_LOOK  = 7'b0000100,
		S_DENSE = 7'b0001000,
		S_LAST  = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_REM2  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_UPDATE = 2'd2,
		ACT_REMOVE = 2'd3
	} act_t;

	state_t state_q, state_d;
	logic [IW-1:0]   clr_q;
	logic [CW-1:0]   count_q;
	cmd_t            cmd_q;
	logic [IW-1:0]   pos_q;
	res_t            res_q;
	act_t            act_q;
	logic [ID_W-1:0] moved_q;
	logic [DATA_WIDTH-1:0] mdata_q;

	logic [SPW-1:0]        sp_rdata, sp_wdata;
	logic [IW-1:0]         sp_raddr, sp_waddr;
	logic                  sp_we;
	logic [ID_W-1:0]       own_rdata, own_wdata;
	logic [DATA_WIDTH-1:0] dat_rdata, dat_wdata;
	logic [IW-1:0]         dn_raddr, dn_waddr;
	logic                  own_we, dat_we;

	logic [31:0] link_id_ext, link_pos_ext, id_ext, pos_in_ext, pos_ext;
	logic [31:0] cnt_ext, cnt_p1_ext, cnt_m1_ext, moved_ext;
	logic [63:0] wd_ext, rd_ext;
	logic [DATA_WIDTH-1:0] wd;
	logic          sp_valid;
	logic [IW-1:0] sp_ptr;
	logic          present;
	logic          can_ins;
	logic [CW-1:0] cnt_m1;
	logic          res_full;
	logic          res_push;
	res_t          look_res, dense_res;
	act_t          look_act;
	logic [$bits(res_t)-1:0] res_dout;

	always_comb begin
		link_id_ext  = 32'(f2b.cmd.key_id);
		link_pos_ext = 32'(f2b.cmd.dense_index);
		id_ext       = 32'(cmd_q.key_id);
		pos_in_ext   = 32'(cmd_q.dense_index);
		pos_ext      = 32'(pos_q);
		cnt_m1       = count_q - CW'(1);
		cnt_ext      = 32'(count_q);
		cnt_p1_ext   = cnt_ext + 32'd1;
		cnt_m1_ext   = 32'(cnt_m1);
		moved_ext    = 32'(moved_q);
		wd_ext       = 64'(cmd_q.write_data);
		wd           = wd_ext[DATA_WIDTH-1:0];
		rd_ext       = 64'(dat_rdata);
		sp_valid     = sp_rdata[IW];
		sp_ptr       = sp_rdata[IW-1:0];
		present      = cmd_q.in_range && sp_valid && (32'(sp_ptr) < cnt_ext);
		can_ins      = cmd_q.in_range && (cnt_ext < MAX_ENTITIES);
	end

	// result and action decided once the sparse entry is back
	always_comb begin
		look_res             = '0;
		look_res.status      = ST_OK;
		look_res.entry_total = cnt_ext[TOT_W-1:0];
		look_act             = ACT_NONE;
		case (cmd_q.kind)
			REQ_READ_AT: begin
				if (cmd_q.pos_ok && (pos_in_ext < cnt_ext)) begin
					look_res.owner_id  = own_rdata;
					look_res.read_data = rd_ext[RD_W-1:0];
					look_res.slot      = cmd_q.dense_index;
				end else begin
					look_res.status = ST_RANGE;
				end
			end
			REQ_SET: begin
				if (present) begin
					look_act = ACT_UPDATE;
				end else if (can_ins) begin
					look_act             = ACT_INSERT;
					look_res.owner_id    = cmd_q.key_id;
					look_res.slot        = cnt_ext[POS_W-1:0];
					look_res.entry_total = cnt_p1_ext[TOT_W-1:0];
				end else begin
					look_res.status = ST_ABSENT;
				end
			end
			REQ_REMOVE: begin
				if (present) begin
					look_act = ACT_REMOVE;
				end else begin
					look_res.status = ST_ABSENT;
				end
			end
			default: begin
				if (!present) begin
					look_res.status = ST_ABSENT;
				end
			end
		endcase
	end

	always_comb begin
		dense_res             = '0;
		dense_res.status      = ST_OK;
		dense_res.found       = 1'b1;
		dense_res.owner_id    = cmd_q.key_id;
		dense_res.read_data   = rd_ext[RD_W-1:0];
		dense_res.slot        = pos_ext[POS_W-1:0];
		dense_res.entry_total = (act_q == ACT_REMOVE) ? cnt_m1_ext[TOT_W-1:0]
			: cnt_ext[TOT_W-1:0];
	end

	assign res_push = (state_q == S_FIN) && !res_full;

	always_comb begin
		state_d      = state_q;
		sp_raddr     = link_id_ext[IW-1:0];
		dn_raddr     = link_pos_ext[IW-1:0];
		sp_we        = 1'b0;
		sp_waddr     = id_ext[IW-1:0];
		sp_wdata     = '0;
		own_we       = 1'b0;
		dat_we       = 1'b0;
		dn_waddr     = pos_q;
		own_wdata    = moved_q;
		dat_wdata    = mdata_q;
		b2f.take     = 1'b0;
		b2f.clearing = (state_q == S_CLEAR);
		case (state_q)
			S_CLEAR: begin
				sp_we    = 1'b1;
				sp_waddr = clr_q;
				if (clr_q == IW'(MAX_ENTITIES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (f2b.valid) begin
					b2f.take = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				dn_raddr = sp_ptr;
				if (cmd_q.kind != REQ_READ_AT && present) begin
					state_d = S_DENSE;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DENSE: begin
				dn_raddr = cnt_m1[IW-1:0];
				state_d  = (act_q == ACT_REMOVE) ? S_LAST : S_FIN;
			end
			S_LAST: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!res_full) begin
					case (act_q)
						ACT_INSERT: begin
							sp_we     = 1'b1;
							sp_wdata  = {1'b1, count_q[IW-1:0]};
							own_we    = 1'b1;
							dat_we    = 1'b1;
							dn_waddr  = count_q[IW-1:0];
							own_wdata = cmd_q.key_id;
							dat_wdata = wd;
						end
						ACT_UPDATE: begin
							dat_we    = 1'b1;
							dat_wdata = wd;
						end
						ACT_REMOVE: begin
							sp_we    = 1'b1;
							sp_waddr = moved_ext[IW-1:0];
							sp_wdata = {1'b1, pos_q};
							own_we   = 1'b1;
							dat_we   = 1'b1;
						end
						default: ;
					endcase
					state_d = (act_q == ACT_REMOVE) ? S_REM2 : S_IDLE;
				end
			end
			S_REM2: begin
				// invalidate the removed id after the moved entry is repointed
				sp_we   = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (res_push && act_q == ACT_INSERT) begin
				count_q <= count_q + CW'(1);
			end else if (res_push && act_q == ACT_REMOVE) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (f2b.valid) begin
					cmd_q <= f2b.cmd;
				end
			end
			S_LOOK: begin
				pos_q <= sp_ptr;
				res_q <= look_res;
				act_q <= look_act;
			end
			S_DENSE: begin
				res_q <= dense_res;
			end
			S_LAST: begin
				moved_q <= own_rdata;
				mdata_q <= dat_rdata;
			end
			default: ;
		endcase
	end

	ssc_ram #(.WIDTH(SPW), .DEPTH(MAX_ENTITIES)) u_sparse (
		.clk  (clk),
		.we   (sp_we),
		.waddr(sp_waddr),
		.wdata(sp_wdata),
		.raddr(sp_raddr),
		.rdata(sp_rdata)
	);

	ssc_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTITIES)) u_owner (
		.clk  (clk),
		.we   (own_we),
		.waddr(dn_waddr),
		.wdata(own_wdata),
		.raddr(dn_raddr),
		.rdata(own_rdata)
	);

	ssc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ENTITIES)) u_data (
		.clk  (clk),
		.we   (dat_we),
		.waddr(dn_waddr),
		.wdata(dat_wdata),
		.raddr(dn_raddr),
		.rdata(dat_rdata)
	);

	ssc_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_q),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_dout),
		.empty (empty)
	);

	assign res = res_t'(res_dout);

endmodule

>>> design/sparse_set_component_store_unit.sv
// sparse set component store: request queue, classifying front end, memory back end
// the back end sequencer settles read-at, absent id and insert after its first reads of the
// memories, lookup and overwrite after a further dense read and remove after a read of the
// last entry as well; its three single-read-port memories are read one step at a time
// one request in the back end at a time
// after reset full stays high while the sparse table is cleared
module sparse_set_component_store_unit import ssc_pkg::*; #(
	parameter int MAX_ENTITIES = 1024,
	parameter int DATA_WIDTH   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        req_type,
	input  logic [ID_W-1:0]   key_id,
	input  logic [POS_W-1:0]  dense_index,
	input  logic [WD_W-1:0]   write_data,
	output logic              empty,
	input  logic              pop,
	output logic [STAT_W-1:0] status,
	output logic              found,
	output logic [ID_W-1:0]   owner_id,
	output logic [RD_W-1:0]   read_data,
	output logic [POS_W-1:0]  slot,
	output logic [TOT_W-1:0]  entry_total
);

	f2b_t f2b;
	b2f_t b2f;
	res_t res;

	ssc_front #(.MAX_ENTITIES(MAX_ENTITIES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.key_id     (key_id),
		.dense_index(dense_index),
		.write_data (write_data),
		.f2b        (f2b),
		.b2f        (b2f)
	);

	ssc_back #(
		.MAX_ENTITIES(MAX_ENTITIES),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.f2b   (f2b),
		.b2f   (b2f),
		.pop   (pop),
		.empty (empty),
		.res   (res)
	);

	assign status      = res.status;
	assign found       = res.found;
	assign owner_id    = res.owner_id;
	assign read_data   = res.read_data;
	assign slot        = res.slot;
	assign entry_total = res.entry_total;

endmodule

>>> design/ssc_checker.sv
// port level checks of the sparse set component store, bound to the top level
// depends on ssc_pkg and sparse_set_component_store_unit
module ssc_checker import ssc_pkg::*; #(
	parameter int MAX_ENTITIES = 1024
) (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input logic [STAT_W-1:0] status,
	input logic              found,
	input logic [ID_W-1:0]   owner_id,
	input logic [RD_W-1:0]   read_data,
	input logic [POS_W-1:0]  slot,
	input logic [TOT_W-1:0]  entry_total
);

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(entry_total) <= MAX_ENTITIES))
		else $error("entry total beyond capacity");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |->
		(!found && owner_id == '0 && slot == '0 && read_data == '0))
		else $error("failed request carries non-zero fields");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && found) |-> (status == ST_OK))
		else $error("found set on a failed request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=>
		(!empty && $stable(read_data) && $stable(slot) && $stable(entry_total)))
		else $error("waiting result changed");

endmodule

bind sparse_set_component_store_unit ssc_checker #(.MAX_ENTITIES(MAX_ENTITIES)) u_ssc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.status     (status),
	.found      (found),
	.owner_id   (owner_id),
	.read_data  (read_data),
	.slot       (slot),
	.entry_total(entry_total)
);
